FILE: sv/allx_pkg.sv
// Package: shared types, tables and constants for the ambient light lux level block.
package allx_pkg;

    localparam int unsigned LUX_W = 28;
    localparam int unsigned LVL_W = 17;
    localparam int unsigned LOG_W = 21;  // 5 integer bits, 16 fraction bits
    localparam logic [LUX_W-1:0] LUX_SAT = 28'hFFFFFFF;
    localparam logic [LVL_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG = 3'd1;
    localparam logic [2:0] REG_LMIN  = 3'd2;
    localparam logic [2:0] REG_LMAX  = 3'd3;
    localparam logic [2:0] REG_ALPHA = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LUX,
        ST_DIV,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_NEXT,
        ST_LVL_DIV,
        ST_EMA,
        ST_OUT
    } allx_state_t;

    // Gain factor by code; reserved codes count as 1x
    function automatic logic [6:0] gain_of(input logic [2:0] code);
        logic [6:0] g;
        begin
            case (code)
                3'd0: g = 7'd1;
                3'd1: g = 7'd2;
                3'd2: g = 7'd4;
                3'd3: g = 7'd8;
                3'd6: g = 7'd48;
                3'd7: g = 7'd96;
                default: g = 7'd1;
            endcase
            return g;
        end
    endfunction

    // Integration time in ms by code
    function automatic logic [8:0] time_of(input logic [2:0] code);
        logic [8:0] t;
        begin
            case (code)
                3'd0: t = 9'd100;
                3'd1: t = 9'd50;
                3'd2: t = 9'd200;
                3'd3: t = 9'd400;
                3'd4: t = 9'd150;
                3'd5: t = 9'd250;
                3'd6: t = 9'd300;
                default: t = 9'd350;
            endcase
            return t;
        end
    endfunction

endpackage

FILE: sv/ambient_light_lux_level.sv
// Top level: ambient light lux meter with log-scaled, smoothed level output.
// One reading is taken at a time. A reading with new data runs the lux division and the level
// division, both on one shared bit-serial divider, and three log2 evaluations of up to 28
// normalise steps, 16 squaring steps on the shared 32x32 multiplier and one store step each.
// The level division is skipped when the level clamps. A reading without new data skips
// both divisions and the log2 evaluations.
// The result sits in an output register; input is accepted again only once it is taken.
module ambient_light_lux_level
    import allx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             data_new,
    input  logic [15:0]      visible_count,
    input  logic [15:0]      infrared_count,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             valid_res,
    output logic [LUX_W-1:0] lux,
    output logic [LVL_W-1:0] level,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [19:0]      cfg_data
);

    logic [2:0]       gain_reg, integ_reg;
    logic [19:0]      lmin_reg, lmax_reg;
    logic [16:0]      alpha_reg;
    logic             ov_reg;
    logic             vr_reg;
    logic [LUX_W-1:0] lux_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic             busy, finish, c_vres;
    logic [LUX_W-1:0] c_lux;
    logic [LVL_W-1:0] c_lvl;
    logic             start;

    assign start     = in_valid && in_ready;
    assign in_ready  = !busy && !ov_reg && !finish;
    assign cfg_ready = 1'b1;

    allx_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .data_new         (data_new),
        .visible_count    (visible_count),
        .infrared_count   (infrared_count),
        .gain_code        (gain_reg),
        .integration_code (integ_reg),
        .lux_min          (lmin_reg),
        .lux_max          (lmax_reg),
        .smooth_weight    (alpha_reg),
        .busy             (busy),
        .finish           (finish),
        .valid_res        (c_vres),
        .lux              (c_lux),
        .level            (c_lvl)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 3'd0;
            integ_reg <= 3'd0;
            lmin_reg  <= 20'd1;
            lmax_reg  <= 20'd10000;
            alpha_reg <= 17'd6554;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN:  gain_reg  <= cfg_data[2:0];
                REG_INTEG: integ_reg <= cfg_data[2:0];
                REG_LMIN:  lmin_reg  <= cfg_data;
                REG_LMAX:  lmax_reg  <= cfg_data;
                REG_ALPHA: alpha_reg <= 17'(cfg_data);
                default:   ;
            endcase
        end
    end

    // Output register: load on finish, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (finish)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            vr_reg  <= c_vres;
            lux_reg <= c_lux;
            lvl_reg <= c_lvl;
        end
    end

    assign out_valid = ov_reg;
    assign valid_res = vr_reg;
    assign lux       = lux_reg;
    assign level     = lvl_reg;

endmodule

FILE: sv/allx_divider.sv
// Restoring divider: one quotient bit per cycle, shared by the lux and level divisions.
module allx_divider
    import allx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [23:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [47:0] quotient
);

    logic [47:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;
    logic [24:0] diff;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        trial      = {rem_reg[23:0], quo_reg[47]};
        diff       = trial - {1'b0, dsr_reg};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[24])
            begin
                rem_next = diff;
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/allx_core.sv
// Sequencer and shared multiplier datapath for lux, log2 mapping and smoothing.
module allx_core
    import allx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             data_new,
    input  logic [15:0]      visible_count,
    input  logic [15:0]      infrared_count,
    input  logic [2:0]       gain_code,
    input  logic [2:0]       integration_code,
    input  logic [19:0]      lux_min,
    input  logic [19:0]      lux_max,
    input  logic [16:0]      smooth_weight,
    output logic             busy,
    output logic             finish,
    output logic             valid_res,
    output logic [LUX_W-1:0] lux,
    output logic [LVL_W-1:0] level
);

    allx_state_t state_reg, state_next;

    logic [15:0]      v_reg, r_reg;
    logic             new_reg;
    logic [LUX_W-1:0] lux_reg, lux_next;
    logic [LVL_W-1:0] sm_reg, sm_next;
    logic             seeded_reg, seeded_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [1:0]       which_reg, which_next;   // log operand: 0 A, 1 B, 2 L
    logic [LOG_W-1:0] la_reg, la_next, lb_reg, lb_next, ll_reg, ll_next;
    logic [28:0]      x_reg, x_next;
    logic [4:0]       n_reg, n_next;
    logic [31:0]      y_reg, y_next;
    logic [15:0]      fr_reg, fr_next;
    logic [4:0]       k_reg, k_next;
    logic             fin_reg, fin_next;
    logic             vres_reg, vres_next;

    logic [63:0]      sq;
    logic [33:0]      ysh;
    logic [16:0]      s;
    logic [23:0]      ps, p45, p64, p85;
    logic [32:0]      n_lux;
    logic [31:0]      pv, pr;
    logic [23:0]      den;
    logic [16:0]      alpha_c;
    logic [49:0]      acc;
    logic [19:0]      lo_c, hi_c;
    logic             div_start;
    logic [47:0]      div_dividend;
    logic [23:0]      div_divisor;
    logic             div_busy, div_done;
    logic [47:0]      div_q;
    logic [LOG_W-1:0] num, dnm;

    allx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Single 32x32 squaring unit for the log fraction
    assign sq  = y_reg * y_reg;
    assign ysh = sq[63:30];

    // Lux formula selection and coefficients
    always_comb
    begin
        s   = {1'b0, v_reg} + {1'b0, r_reg};
        ps  = 24'(r_reg) * 24'd100;
        p45 = 24'(s) * 24'd45;
        p64 = 24'(s) * 24'd64;
        p85 = 24'(s) * 24'd85;
        pv  = '0;
        pr  = '0;
        n_lux = '0;
        if (ps < p45)
        begin
            n_lux = 33'(32'(v_reg) * 32'd17743) + 33'(32'(r_reg) * 32'd11059);
        end
        else if (ps < p64)
        begin
            pv = 32'(v_reg) * 32'd42785;
            pr = 32'(r_reg) * 32'd19548;
            n_lux = (pv > pr) ? 33'(pv - pr) : 33'd0;
        end
        else if (ps < p85)
        begin
            n_lux = 33'(32'(v_reg) * 32'd5926) + 33'(32'(r_reg) * 32'd1185);
        end
        den     = 24'(gain_of(gain_code)) * 24'(time_of(integration_code)) * 24'd100;
        alpha_c = (smooth_weight > ONE_Q16) ? ONE_Q16 : smooth_weight;
        acc     = 50'(sm_reg) * 50'(ONE_Q16 - alpha_c) + 50'(lvl_reg) * 50'(alpha_c)
                  + 50'd32768;
        lo_c    = (lux_min == 20'd0) ? 20'd1 : lux_min;
        hi_c    = (lux_max == 20'd0) ? 20'd1 : lux_max;
        num     = ll_reg - la_reg;
        dnm     = lb_reg - la_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        lux_next     = lux_reg;
        sm_next      = sm_reg;
        seeded_next  = seeded_reg;
        lvl_next     = lvl_reg;
        which_next   = which_reg;
        la_next      = la_reg;
        lb_next      = lb_reg;
        ll_next      = ll_reg;
        x_next       = x_reg;
        n_next       = n_reg;
        y_next       = y_reg;
        fr_next      = fr_reg;
        k_next       = k_reg;
        fin_next     = 1'b0;
        vres_next    = vres_reg;
        div_start    = 1'b0;
        div_dividend = {7'd0, n_lux, 8'd0};
        div_divisor  = den;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LUX;
                end
            end
            ST_LUX:
            begin
                if (!new_reg)
                begin
                    vres_next  = 1'b0;
                    lux_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    lux_next   = (|div_q[47:LUX_W]) ? LUX_SAT : div_q[LUX_W-1:0];
                    which_next = 2'd0;
                    x_next     = {1'b0, lo_c, 8'd0};
                    n_next     = '0;
                    state_next = ST_LOG_NORM;
                end
            end
            ST_LOG_NORM:
            begin
                // Find MSB index one bit per cycle
                if (x_reg[28:1] >> n_reg != 28'd0)
                begin
                    n_next = n_reg + 5'd1;
                end
                else
                begin
                    y_next     = 32'(x_reg) << (5'd30 - n_reg);
                    fr_next    = '0;
                    k_next     = '0;
                    state_next = ST_LOG_SQ;
                end
            end
            ST_LOG_SQ:
            begin
                if (ysh[33:31] != 3'd0)
                begin
                    y_next  = ysh[32:1];
                    fr_next = {fr_reg[14:0], 1'b1};
                end
                else
                begin
                    y_next  = ysh[31:0];
                    fr_next = {fr_reg[14:0], 1'b0};
                end
                k_next = k_reg + 5'd1;
                if (k_reg == 5'd15)
                begin
                    state_next = ST_LOG_NEXT;
                end
            end
            ST_LOG_NEXT:
            begin
                n_next = '0;
                state_next = ST_LOG_NORM;
                unique case (which_reg)
                    2'd0:
                    begin
                        la_next    = {n_reg, fr_reg};
                        which_next = 2'd1;
                        x_next     = {1'b0, hi_c, 8'd0};
                    end
                    2'd1:
                    begin
                        lb_next    = {n_reg, fr_reg};
                        which_next = 2'd2;
                        x_next     = (lux_reg < 28'd256) ? 29'd256 : {1'b0, lux_reg};
                    end
                    default:
                    begin
                        ll_next    = {n_reg, fr_reg};
                        state_next = ST_LVL_DIV;
                    end
                endcase
            end
            ST_LVL_DIV:
            begin
                if (lb_reg <= la_reg || ll_reg <= la_reg)
                begin
                    lvl_next   = '0;
                    state_next = ST_EMA;
                end
                else if (num >= dnm)
                begin
                    lvl_next   = ONE_Q16;
                    state_next = ST_EMA;
                end
                else if (!div_busy && !div_done)
                begin
                    div_dividend = {11'd0, num, 16'd0};
                    div_divisor  = 24'(dnm);
                    div_start    = 1'b1;
                end
                else if (div_done)
                begin
                    lvl_next   = div_q[LVL_W-1:0];
                    state_next = ST_EMA;
                end
            end
            ST_EMA:
            begin
                if (!seeded_reg)
                begin
                    sm_next     = lvl_reg;
                    seeded_next = 1'b1;
                end
                else
                begin
                    sm_next = acc[16+LVL_W-1:16];
                end
                vres_next  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                fin_next   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sm_reg     <= '0;
            seeded_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sm_reg     <= sm_next;
            seeded_reg <= seeded_next;
            fin_reg    <= fin_next;
        end
    end

    // Hold payload and working values
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= visible_count;
            r_reg   <= infrared_count;
            new_reg <= data_new;
        end
        lux_reg   <= lux_next;
        lvl_reg   <= lvl_next;
        which_reg <= which_next;
        la_reg    <= la_next;
        lb_reg    <= lb_next;
        ll_reg    <= ll_next;
        x_reg     <= x_next;
        n_reg     <= n_next;
        y_reg     <= y_next;
        fr_reg    <= fr_next;
        k_reg     <= k_next;
        vres_reg  <= vres_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign finish    = fin_reg;
    assign valid_res = vres_reg;
    assign lux       = lux_reg;
    assign level     = sm_reg;

endmodule
